// ===== rtl/core/fckv_pkg.sv =====
// Shared types and constants for the fixed-capacity key-value table.
`default_nettype none
package fckv_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_RESET = (16 > TABLE_DEPTH) ? TABLE_DEPTH : 16;

  localparam int DATA_W = 32;
  localparam int LIMIT_W = 5;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_ENTRY_LIMIT = 3'd0;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_DONE      = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] key_first;
    logic [DATA_W-1:0] key_second;
    logic [DATA_W-1:0] value_first;
    logic [DATA_W-1:0] value_second;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    scan_step;
    logic    rd_last;
    logic    take_found;
    logic    wr_update;
    logic    wr_insert;
    logic    wr_move;
    logic    res_load;
    status_t res_status;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic hit;
    logic scan_end;
    logic room;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/fixed_capacity_key_value_table.sv =====
// Top level of the fixed-capacity key-value table with its register port.
// Each command scans the occupied entries one per cycle through the entry memory read port;
// a remove that hits adds a move step, and the result waits out any output stall.
// One command is worked on at a time; the next is taken while the last result waits.
// Synchronous reset empties the table and sets the entry limit to sixteen.
// Writing the entry limit also empties the table.
`default_nettype none
module fixed_capacity_key_value_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [fckv_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          command,
  input  wire logic signed [fckv_pkg::DATA_W-1:0]  key_first,
  input  wire logic signed [fckv_pkg::DATA_W-1:0]  key_second,
  input  wire logic signed [fckv_pkg::DATA_W-1:0]  value_first,
  input  wire logic signed [fckv_pkg::DATA_W-1:0]  value_second,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               status,
  output logic signed [fckv_pkg::DATA_W-1:0]       found_first,
  output logic signed [fckv_pkg::DATA_W-1:0]       found_second,
  output logic [fckv_pkg::LIMIT_W-1:0]             occupied
);
  import fckv_pkg::*;

  ctrl_t             ctrl;
  stat_t             stat;
  logic              cfg_write;
  logic [CNT_W-1:0]  limit;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_ENTRY_LIMIT);
  assign prdata = (paddr == ADDR_ENTRY_LIMIT) ? 32'(limit) : '0;

  fckv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  fckv_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_limit    (pwdata[LIMIT_W-1:0]),
    .limit        (limit),
    .command      (command),
    .key_first    (key_first),
    .key_second   (key_second),
    .value_first  (value_first),
    .value_second (value_second),
    .status       (status),
    .found_first  (found_first),
    .found_second (found_second),
    .occupied     (occupied)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input transfer taken while a command was in progress.");

  a_full_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (CNT_W'(occupied) == limit))
    else $error("Full reported below the entry limit.");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND) |-> (found_first == '0) && (found_second == '0))
    else $error("Nonzero value returned for a missing key.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.res_load |=> (CNT_W'(occupied) <= limit))
    else $error("Occupied count exceeds the entry limit.");

endmodule
`default_nettype wire

// ===== rtl/core/fckv_ctrl.sv =====
// Command sequencer for the key-value table: scan, update, insert and remove steps.
`default_nettype none
module fckv_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire fckv_pkg::stat_t stat,
  output fckv_pkg::ctrl_t      ctrl
);
  import fckv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_FINISH
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t res_code;
  status_t res_code_next;
  logic    out_valid_next;

  always_comb begin
    ctrl = '0;
    ctrl.res_status = res_code;
    state_next = state;
    res_code_next = res_code;
    in_ready = (state == S_IDLE);
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.cmd == CMD_NONE) begin
          res_code_next = ST_NOT_FOUND;
          state_next = S_FINISH;
        end else if (stat.hit) begin
          res_code_next = ST_DONE;
          state_next = S_FINISH;
          case (stat.cmd)
            CMD_PUT: begin
              ctrl.wr_update = 1'b1;
            end
            CMD_GET: begin
              ctrl.take_found = 1'b1;
            end
            CMD_REMOVE: begin
              ctrl.take_found = 1'b1;
              ctrl.rd_last = 1'b1;
              state_next = S_MOVE;
            end
            default: begin
              res_code_next = ST_NOT_FOUND;
            end
          endcase
        end else if (stat.scan_end) begin
          state_next = S_FINISH;
          if (stat.cmd == CMD_PUT) begin
            if (stat.room) begin
              ctrl.wr_insert = 1'b1;
              res_code_next = ST_DONE;
            end else begin
              res_code_next = ST_FULL;
            end
          end else begin
            res_code_next = ST_NOT_FOUND;
          end
        end else begin
          ctrl.scan_step = 1'b1;
        end
      end
      S_MOVE: begin
        ctrl.wr_move = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctrl.res_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      res_code <= ST_NOT_FOUND;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      res_code <= res_code_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fckv_datapath.sv =====
// Entry memory, scan pointer, occupancy count, limit register and result registers.
`default_nettype none
module fckv_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fckv_pkg::ctrl_t               ctrl,
  output fckv_pkg::stat_t                    stat,
  input  wire logic                          cfg_write,
  input  wire logic [fckv_pkg::LIMIT_W-1:0]  cfg_limit,
  output logic [fckv_pkg::CNT_W-1:0]         limit,
  input  wire logic [1:0]                    command,
  input  wire logic [fckv_pkg::DATA_W-1:0]   key_first,
  input  wire logic [fckv_pkg::DATA_W-1:0]   key_second,
  input  wire logic [fckv_pkg::DATA_W-1:0]   value_first,
  input  wire logic [fckv_pkg::DATA_W-1:0]   value_second,
  output logic [1:0]                         status,
  output logic [fckv_pkg::DATA_W-1:0]        found_first,
  output logic [fckv_pkg::DATA_W-1:0]        found_second,
  output logic [fckv_pkg::LIMIT_W-1:0]       occupied
);
  import fckv_pkg::*;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data;
  entry_t             req;
  entry_t             wr_data;
  cmd_t               req_cmd;
  logic [CNT_W-1:0]   ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_last;
  logic [IDX_W-1:0]   cmp_idx;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;
  logic               cmp_ok;
  logic [DATA_W-1:0]  hold_first;
  logic [DATA_W-1:0]  hold_second;

  assign count_last = count - CNT_W'(1);
  assign rd_addr = ctrl.rd_last ? count_last[IDX_W-1:0] : ptr[IDX_W-1:0];

  always_comb begin
    wr_en = ctrl.wr_update || ctrl.wr_insert || ctrl.wr_move;
    wr_addr = cmp_idx;
    wr_data = req;
    if (ctrl.wr_insert) begin
      wr_addr = count[IDX_W-1:0];
    end else if (ctrl.wr_move) begin
      wr_data = rd_data;
    end
  end

  assign stat.cmd = req_cmd;
  assign stat.hit = cmp_ok && (rd_data.key_first == req.key_first)
                    && (rd_data.key_second == req.key_second);
  assign stat.scan_end = (ptr == count);
  assign stat.room = (count < limit);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_cmd <= cmd_t'(command);
      req.key_first <= key_first;
      req.key_second <= key_second;
      req.value_first <= value_first;
      req.value_second <= value_second;
      hold_first <= '0;
      hold_second <= '0;
    end else if (ctrl.take_found) begin
      hold_first <= rd_data.value_first;
      hold_second <= rd_data.value_second;
    end
    if (ctrl.scan_step) begin
      cmp_idx <= ptr[IDX_W-1:0];
    end
    if (ctrl.res_load) begin
      found_first <= hold_first;
      found_second <= hold_second;
      occupied <= LIMIT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      cmp_ok <= 1'b0;
      count <= '0;
      limit <= CNT_W'(LIMIT_RESET);
      status <= ST_NOT_FOUND;
    end else begin
      if (ctrl.capture) begin
        ptr <= '0;
        cmp_ok <= 1'b0;
      end else if (ctrl.scan_step) begin
        ptr <= ptr + CNT_W'(1);
        cmp_ok <= 1'b1;
      end
      if (cfg_write) begin
        count <= '0;
        if (int'(cfg_limit) > TABLE_DEPTH) begin
          limit <= CNT_W'(TABLE_DEPTH);
        end else begin
          limit <= CNT_W'(cfg_limit);
        end
      end else if (ctrl.wr_insert) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.wr_move) begin
        count <= count_last;
      end
      if (ctrl.res_load) begin
        status <= ctrl.res_status;
      end
    end
  end

endmodule
`default_nettype wire
